>>> rtl/omrs_pkg.sv
// Shared types and constants for the ordered multiset rank/select unit.
// No dependencies; imported by omrs_cell, omrs_or_tree and the top level.
package omrs_pkg;

    localparam int VAL_W  = 32;
    localparam int RANK_W = 11;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    // Reduction tree fan-in per registered level
    localparam int TREE_FAN = 16;

    // Leaf word layout during the position search
    localparam int HIT_BIT = 31;
    localparam int EQ_BIT  = 30;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_RANK   = 3'd2,
        OP_SELECT = 3'd3,
        OP_PRED   = 3'd4,
        OP_SUCC   = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic ins_en;   // shift right and drop the key in at the boundary
        logic del_en;   // shift left from the boundary onwards
        logic use_le;   // boundary on value <= key instead of value < key
        logic fetch;    // leaves carry the value of the addressed cell
    } cell_ctrl_t;

    // Registered levels needed to reduce the given number of leaves
    function automatic int tree_levels(input int leaves);
        int lv;
        int span;
        lv   = 1;
        span = TREE_FAN;
        while (span < leaves)
        begin
            span = span * TREE_FAN;
            lv   = lv + 1;
        end
        return lv;
    endfunction

endpackage

>>> rtl/omrs_cell.sv
// One storage cell of the sorted chain: holds a value, compares it with the
// broadcast key and shifts to or from its neighbours. Depends on omrs_pkg.
module omrs_cell #(
    parameter int IDXW = 10,
    parameter int IDX  = 0
) (
    input  logic                                clk,
    input  omrs_pkg::cell_ctrl_t                ctrl,
    input  logic signed [omrs_pkg::VAL_W-1:0]   key,
    input  logic [IDXW-1:0]                     q,
    input  logic                                valid,
    input  logic                                prev_f,
    input  logic signed [omrs_pkg::VAL_W-1:0]   prev_value,
    input  logic signed [omrs_pkg::VAL_W-1:0]   next_value,
    output logic signed [omrs_pkg::VAL_W-1:0]   value,
    output logic                                f,
    output logic                                bnd,
    output logic [omrs_pkg::VAL_W-1:0]          leaf
);
    import omrs_pkg::*;

    localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    logic                    lt;
    logic                    le;
    logic                    eq;
    logic [VAL_W-1:0]        leaf_pos;

    assign lt = valid && (value_reg < key);
    assign le = valid && (value_reg <= key);
    assign eq = valid && (value_reg == key);
    assign f  = ctrl.use_le ? le : lt;

    // First cell whose flag drops: the insert/search position
    assign bnd = prev_f && !f;

    always_comb
    begin
        leaf_pos             = '0;
        leaf_pos[HIT_BIT]    = 1'b1;
        leaf_pos[EQ_BIT]     = eq;
        leaf_pos[IDXW-1:0]   = MY_IDX;
    end

    always_comb
    begin
        if (ctrl.fetch)
        begin
            leaf = (q == MY_IDX) ? value_reg : '0;
        end
        else
        begin
            leaf = bnd ? leaf_pos : '0;
        end
    end

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins_en && !f)
        begin
            value_next = prev_f ? key : prev_value;
        end
        else if (ctrl.del_en && !f)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

>>> rtl/omrs_or_tree.sv
// Registered OR-reduction tree over the cell leaves; at most one leaf is
// non-zero, so the root yields it. Depends on omrs_pkg.
module omrs_or_tree #(
    parameter int LEAVES = 1024
) (
    input  logic                        clk,
    input  logic [omrs_pkg::VAL_W-1:0]  leaf [LEAVES],
    output logic [omrs_pkg::VAL_W-1:0]  root
);
    import omrs_pkg::*;

    localparam int LVLS = tree_levels(LEAVES);
    localparam int PAD  = TREE_FAN ** LVLS;

    // First node slot of a level in the flat node array
    function automatic int lvl_base(input int lv);
        int b;
        b = 0;
        for (int j = 1; j < lv; j++)
        begin
            b = b + TREE_FAN ** (LVLS - j);
        end
        return b;
    endfunction

    localparam int TOTAL = lvl_base(LVLS + 1);

    logic [VAL_W-1:0] leaf_pad [PAD];
    logic [VAL_W-1:0] node_reg [TOTAL];

    for (genvar j = 0; j < PAD; j++)
    begin : g_pad
        if (j < LEAVES)
        begin : g_real
            assign leaf_pad[j] = leaf[j];
        end
        else
        begin : g_zero
            assign leaf_pad[j] = '0;
        end
    end

    for (genvar lv = 1; lv <= LVLS; lv++)
    begin : g_lvl
        localparam int NODES = TREE_FAN ** (LVLS - lv);
        for (genvar n = 0; n < NODES; n++)
        begin : g_node
            logic [VAL_W-1:0] acc;
            if (lv == 1)
            begin : g_first
                always_comb
                begin
                    acc = '0;
                    for (int c = 0; c < TREE_FAN; c++)
                    begin
                        acc = acc | leaf_pad[n * TREE_FAN + c];
                    end
                end
            end
            else
            begin : g_upper
                always_comb
                begin
                    acc = '0;
                    for (int c = 0; c < TREE_FAN; c++)
                    begin
                        acc = acc | node_reg[lvl_base(lv - 1) + n * TREE_FAN + c];
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                node_reg[lvl_base(lv) + n] <= acc;
            end
        end
    end

    assign root = node_reg[TOTAL-1];

endmodule

>>> rtl/ordered_multiset_rank_select_unit.sv
// Top level of the ordered multiset: sequencer, occupancy, response register.
// Instantiates omrs_cell (one per entry) and omrs_or_tree; uses omrs_pkg.
//
//   channel | signals                                   | direction
//   req     | req_valid/req_ready, operation, key_value, | into block
//           | rank_index                                 |
//   rsp     | rsp_valid/rsp_ready, result_value,         | out of block
//           | result_rank, status                        |
//
// Insert, no-op, out-of-range select: accept, then S_EXEC (insert: cell update).
// Delete, rank, pred, succ add S_FIND, a search through the registered levels
// of the 16-ary OR tree (3 at 1024); select, pred and succ may add S_FETCH.
// Reset empties the store at once (occupancy cleared; cell contents unused).
// A finished result waits in the response register; the next request is
// taken meanwhile, and its final cycle stalls only while that slot is full.
module ordered_multiset_rank_select_unit #(
    parameter int CAPACITY = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [omrs_pkg::OP_W-1:0]           operation,
    input  logic signed [omrs_pkg::VAL_W-1:0]   key_value,
    input  logic [omrs_pkg::RANK_W-1:0]         rank_index,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic signed [omrs_pkg::VAL_W-1:0]   result_value,
    output logic [omrs_pkg::RANK_W-1:0]         result_rank,
    output logic [omrs_pkg::ST_W-1:0]           status
);
    import omrs_pkg::*;

    localparam int IDXW      = $clog2(CAPACITY);
    localparam int OCCW      = $clog2(CAPACITY + 1);
    localparam int TREE_LVLS = tree_levels(CAPACITY);
    localparam int CNTW      = $clog2(TREE_LVLS + 1);
    localparam int EXTW      = (OCCW + 1 > RANK_W) ? OCCW + 1 : RANK_W;
    localparam int CMPW      = (OCCW > RANK_W) ? OCCW : RANK_W;

    localparam logic [OCCW-1:0] OCC_FULL = OCCW'(CAPACITY);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(TREE_LVLS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_FIND  = 4'b0100,
        S_FETCH = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    logic [RANK_W-1:0]       rank_reg, rank_next;
    logic [OCCW-1:0]         occ_reg, occ_next;
    logic [IDXW-1:0]         q_reg, q_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;

    logic                    rsp_valid_reg, rsp_valid_next;
    logic signed [VAL_W-1:0] rval_reg, rval_next;
    logic [RANK_W-1:0]       rrank_reg, rrank_next;
    status_t                 st_reg, st_next;

    cell_ctrl_t              ctrl;
    logic                    ins_en;
    logic                    del_en;
    logic                    slot_free;
    logic                    full;
    logic                    commit;
    logic signed [VAL_W-1:0] c_val;
    logic [RANK_W-1:0]       c_rank;
    status_t                 c_st;

    logic [VAL_W-1:0]        root;
    logic                    root_hit;
    logic                    found;
    logic [OCCW-1:0]         p_pos;
    logic [EXTW-1:0]         rank_sum;

    logic signed [VAL_W-1:0] cell_value [CAPACITY];
    logic [VAL_W-1:0]        cell_leaf  [CAPACITY];
    logic [CAPACITY-1:0]     cell_f;
    logic [CAPACITY-1:0]     cell_bnd;

    // ---------------------------------------------------------------- cells
    assign ctrl = '{ins_en: ins_en,
                    del_en: del_en,
                    use_le: (op_reg == OP_INSERT) || (op_reg == OP_SUCC),
                    fetch:  (state_reg == S_FETCH)};

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                    prev_f;
        logic signed [VAL_W-1:0] prev_value;
        logic signed [VAL_W-1:0] next_value;
        logic                    valid;

        assign valid = (OCCW'(i) < occ_reg);

        if (i == 0)
        begin : g_head
            assign prev_f     = 1'b1;
            assign prev_value = key_reg;
        end
        else
        begin : g_body
            assign prev_f     = cell_f[i-1];
            assign prev_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_value = cell_value[i];
        end
        else
        begin : g_mid
            assign next_value = cell_value[i+1];
        end

        omrs_cell #(
            .IDXW (IDXW),
            .IDX  (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .key        (key_reg),
            .q          (q_reg),
            .valid      (valid),
            .prev_f     (prev_f),
            .prev_value (prev_value),
            .next_value (next_value),
            .value      (cell_value[i]),
            .f          (cell_f[i]),
            .bnd        (cell_bnd[i]),
            .leaf       (cell_leaf[i])
        );
    end

    omrs_or_tree #(
        .LEAVES (CAPACITY)
    ) u_tree (
        .clk  (clk),
        .leaf (cell_leaf),
        .root (root)
    );

    // No boundary at all means every cell is below the key (or equal, with use_le)
    assign root_hit = root[HIT_BIT];
    assign found    = root_hit && root[EQ_BIT];
    assign p_pos    = root_hit ? OCCW'(root[IDXW-1:0]) : occ_reg;
    assign rank_sum = EXTW'(p_pos) + EXTW'(1);

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign full      = (occ_reg == OCC_FULL);

    // ------------------------------------------------------------ sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        rank_next      = rank_reg;
        occ_next       = occ_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rval_next      = rval_reg;
        rrank_next     = rrank_reg;
        st_next        = st_reg;
        commit         = 1'b0;
        c_val          = '0;
        c_rank         = '0;
        c_st           = ST_OK;
        ins_en         = 1'b0;
        del_en         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = operation;
                    key_next   = key_value;
                    rank_next  = rank_index;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        if (slot_free)
                        begin
                            commit = 1'b1;
                            if (full)
                            begin
                                c_st = ST_FULL;
                            end
                            else
                            begin
                                ins_en   = 1'b1;
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                    end
                    OP_SELECT:
                    begin
                        if ((rank_reg == '0) || (CMPW'(rank_reg) > CMPW'(occ_reg)))
                        begin
                            if (slot_free)
                            begin
                                commit = 1'b1;
                                c_st   = ST_NONE;
                            end
                        end
                        else
                        begin
                            q_next     = IDXW'(rank_reg - 1'b1);
                            cnt_next   = '0;
                            state_next = S_FETCH;
                        end
                    end
                    OP_DELETE, OP_RANK, OP_PRED, OP_SUCC:
                    begin
                        // leaves already carry the search result; level 1
                        // is loaded at this edge
                        cnt_next   = CNTW'(1);
                        state_next = S_FIND;
                    end
                    default:
                    begin
                        commit = slot_free;
                    end
                endcase
            end

            S_FIND:
            begin
                if (cnt_reg != CNT_LAST)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    unique case (op_reg)
                        OP_RANK:
                        begin
                            commit = slot_free;
                            c_rank = rank_sum[RANK_W-1:0];
                        end
                        OP_DELETE:
                        begin
                            commit = slot_free;
                            if (slot_free && found)
                            begin
                                del_en   = 1'b1;
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        OP_PRED:
                        begin
                            if (p_pos == '0)
                            begin
                                commit = slot_free;
                                c_st   = ST_NONE;
                            end
                            else
                            begin
                                q_next     = IDXW'(p_pos - 1'b1);
                                cnt_next   = '0;
                                state_next = S_FETCH;
                            end
                        end
                        OP_SUCC:
                        begin
                            if (p_pos >= occ_reg)
                            begin
                                commit = slot_free;
                                c_st   = ST_NONE;
                            end
                            else
                            begin
                                q_next     = IDXW'(p_pos);
                                cnt_next   = '0;
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            commit = slot_free;
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                if (cnt_reg != CNT_LAST)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    commit = slot_free;
                    c_val  = root;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (commit)
        begin
            rsp_valid_next = 1'b1;
            rval_next      = c_val;
            rrank_next     = c_rank;
            st_next        = c_st;
            state_next     = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        rank_reg  <= rank_next;
        q_reg     <= q_next;
        rval_reg  <= rval_next;
        rrank_reg <= rrank_next;
        st_reg    <= st_next;
    end

    assign req_ready    = (state_reg == S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign result_value = rval_reg;
    assign result_rank  = rrank_reg;
    assign status       = st_reg;

    // ----------------------------------------------------------- assertions
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_FULL)
        else $error("occupancy beyond capacity");

    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ins_en |=> (occ_reg == $past(occ_reg) + 1'b1))
        else $error("insert did not grow occupancy by one");

    a_del_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        del_en |-> (occ_reg != '0))
        else $error("delete shift on an empty store");

    a_single_bnd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND) |-> $onehot0(cell_bnd))
        else $error("chain out of order: more than one boundary cell");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (st_reg == ST_NONE)) |-> (rval_reg == '0) && (rrank_reg == '0))
        else $error("missing-element result carries a non-zero field");

endmodule

>>> tb/omrs_result_checker.sv
// Response checker for the ordered multiset rank/select unit: tracks the sorted store
// on every accepted request and compares each response against the predicted result.
// Depends on omrs_pkg for widths, operation and status codes.
module omrs_result_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_ready,
    input  logic [omrs_pkg::OP_W-1:0]           operation,
    input  logic signed [omrs_pkg::VAL_W-1:0]   key_value,
    input  logic [omrs_pkg::RANK_W-1:0]         rank_index,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  logic signed [omrs_pkg::VAL_W-1:0]   result_value,
    input  logic [omrs_pkg::RANK_W-1:0]         result_rank,
    input  logic [omrs_pkg::ST_W-1:0]           status,
    output int                                  fail_count,
    output int                                  responses_seen,
    output int                                  occupancy_now,
    output int                                  peak_occupancy,
    output int                                  dropped_inserts
);
    import omrs_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [RANK_W-1:0] rank;
        status_t           st;
    } omrs_result_t;

    logic signed [VAL_W-1:0] sorted_vals [0:CAPACITY-1];
    int                      stored;
    int                      mismatches = 0;
    int                      seen;
    int                      peak;
    int                      drops;
    omrs_result_t            awaited_results [$];

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH @%0t response %0d: %s got %0d expected %0d",
                 $realtime, seen, what, got, want);
        mismatches++;
    endtask

    function automatic int count_below(input logic signed [VAL_W-1:0] v);
        int n;
        n = 0;
        for (int i = 0; i < stored; i++)
            if (sorted_vals[i] < v)
                n++;
        return n;
    endfunction

    function automatic int count_not_above(input logic signed [VAL_W-1:0] v);
        int n;
        n = 0;
        for (int i = 0; i < stored; i++)
            if (sorted_vals[i] <= v)
                n++;
        return n;
    endfunction

    // Updates the store for one request and returns the response it must produce
    function automatic omrs_result_t multiset_apply(input logic [OP_W-1:0] op,
                                                    input logic signed [VAL_W-1:0] v,
                                                    input logic [RANK_W-1:0] r);
        omrs_result_t res;
        int           p;
        res = '{value: '0, rank: '0, st: ST_OK};
        case (op)
            OP_INSERT:
            begin
                if (stored >= CAPACITY)
                begin
                    res.st = ST_FULL;
                    drops++;
                end
                else
                begin
                    // equal copies keep arrival order: new one goes after them
                    p = count_not_above(v);
                    for (int i = stored; i > p; i--)
                        sorted_vals[i] = sorted_vals[i-1];
                    sorted_vals[p] = v;
                    stored++;
                end
            end
            OP_DELETE:
            begin
                p = count_below(v);
                if (p < stored && sorted_vals[p] == v)
                begin
                    for (int i = p; i < stored - 1; i++)
                        sorted_vals[i] = sorted_vals[i+1];
                    stored--;
                end
            end
            OP_RANK:
                res.rank = RANK_W'(count_below(v) + 1);
            OP_SELECT:
            begin
                if (r == 0 || int'(r) > stored)
                    res.st = ST_NONE;
                else
                    res.value = sorted_vals[r-1];
            end
            OP_PRED:
            begin
                p = count_below(v);
                if (p == 0)
                    res.st = ST_NONE;
                else
                    res.value = sorted_vals[p-1];
            end
            OP_SUCC:
            begin
                p = count_not_above(v);
                if (p >= stored)
                    res.st = ST_NONE;
                else
                    res.value = sorted_vals[p];
            end
            default:
                ;   // spare codes leave the store alone and answer all zero
        endcase
        return res;
    endfunction

    always @(posedge clk)
    begin
        omrs_result_t want;
        if (!rst_n)
        begin
            stored = 0;
            seen   = 0;
            peak   = 0;
            drops  = 0;
            awaited_results.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("unexpected response, status", longint'(status), -1);
                else
                begin
                    want = awaited_results.pop_front();
                    if (result_value !== want.value)
                        report_mismatch("result_value", longint'(result_value),
                                        longint'($signed(want.value)));
                    if (result_rank !== want.rank)
                        report_mismatch("result_rank", longint'(result_rank),
                                        longint'(want.rank));
                    if (status !== want.st)
                        report_mismatch("status", longint'(status), longint'(want.st));
                end
                seen++;
            end
            if (req_valid && req_ready)
                awaited_results.push_back(multiset_apply(operation, key_value, rank_index));
            if (stored > peak)
                peak = stored;
        end
        responses_seen  <= seen;
        occupancy_now   <= stored;
        peak_occupancy  <= peak;
        dropped_inserts <= drops;
    end

endmodule

>>> tb/tb_ordered_multiset_rank_select_unit.sv
// Testbench top for ordered_multiset_rank_select_unit: clock, reset, request stimulus,
// response back-pressure and the verdict. Checking lives in omrs_result_checker.
// Depends on omrs_pkg and the RTL top level.
module tb_ordered_multiset_rank_select_unit;
    import omrs_pkg::*;

    localparam int CAPACITY     = 1024;
    localparam int IDLE_PCT     = 14;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int TAIL_CYCLES  = 16;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam logic signed [VAL_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    req_valid    = 1'b0;
    logic                    req_ready;
    logic [OP_W-1:0]         operation    = '0;
    logic signed [VAL_W-1:0] key_value    = '0;
    logic [RANK_W-1:0]       rank_index   = '0;
    logic                    rsp_valid;
    logic                    rsp_ready    = 1'b0;
    logic signed [VAL_W-1:0] result_value;
    logic [RANK_W-1:0]       result_rank;
    logic [ST_W-1:0]         status;

    logic                    calm         = 1'b1;
    logic                    hold_request = 1'b0;
    int                      requests_sent = 0;
    int                      cycle_count   = 0;
    logic signed [VAL_W-1:0] inserted_keys [$];

    int fail_count;
    int responses_seen;
    int occupancy_now;
    int peak_occupancy;
    int dropped_inserts;

    ordered_multiset_rank_select_unit #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .operation    (operation),
        .key_value    (key_value),
        .rank_index   (rank_index),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .result_value (result_value),
        .result_rank  (result_rank),
        .status       (status)
    );

    omrs_result_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .operation       (operation),
        .key_value       (key_value),
        .rank_index      (rank_index),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .result_value    (result_value),
        .result_rank     (result_rank),
        .status          (status),
        .fail_count      (fail_count),
        .responses_seen  (responses_seen),
        .occupancy_now   (occupancy_now),
        .peak_occupancy  (peak_occupancy),
        .dropped_inserts (dropped_inserts)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d responses seen",
                     cycle_count, responses_seen, requests_sent);
            $display("tb_ordered_multiset_rank_select_unit NOT OK");
            $finish;
        end
    end

    // Response side: random stalls, plus one long hold-off to fill the block up
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [VAL_W-1:0] key,
                                input logic [RANK_W-1:0] rank);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        req_valid  <= 1'b1;
        operation  <= op;
        key_value  <= key;
        rank_index <= rank;
        do @(posedge clk); while (!req_ready);
        requests_sent++;
        if (op == OP_INSERT)
        begin
            inserted_keys.push_back(key);
            if (inserted_keys.size() > 2048)
                void'(inserted_keys.pop_front());
        end
    endtask

    function automatic logic signed [VAL_W-1:0] pick_key(input bit prefer_stored);
        int sel;
        sel = $urandom_range(99);
        if (prefer_stored && inserted_keys.size() > 0 && sel < 60)
            return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        sel = $urandom_range(99);
        if (sel < 45)
            return $signed(32'($urandom_range(40))) - 20;
        if (sel < 60)
        begin
            case ($urandom_range(6))
                0:       return KEY_MIN;
                1:       return KEY_MIN + 1;
                2:       return -1;
                3:       return 0;
                4:       return 1;
                5:       return KEY_MAX - 1;
                default: return KEY_MAX;
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_request(input int ins_pct, input int del_pct);
        int                sel;
        logic [RANK_W-1:0] rank;
        sel  = $urandom_range(99);
        rank = $urandom_range(1) ? RANK_W'($urandom_range(CAPACITY)) :
                                   RANK_W'($urandom_range(64));
        if (sel < ins_pct)
            send_request(OP_INSERT, pick_key(1'b0), RANK_W'($urandom));
        else if (sel < ins_pct + del_pct)
            send_request(OP_DELETE, pick_key(1'b1), RANK_W'($urandom));
        else
        begin
            case ($urandom_range(40))
                0:       send_request($urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI,
                                      $urandom, rank);
                1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
                         send_request(OP_RANK, pick_key(1'b1), rank);
                11, 12, 13, 14, 15, 16, 17, 18, 19, 20:
                         send_request(OP_SELECT, $urandom, rank);
                21, 22, 23, 24, 25, 26, 27, 28, 29, 30:
                         send_request(OP_PRED, pick_key(1'b1), rank);
                default: send_request(OP_SUCC, pick_key(1'b1), rank);
            endcase
        end
    endtask

    initial
    begin
        int guard;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-store queries, extremes, duplicates, absent deletes
        send_request(OP_SELECT, 0, 1);
        send_request(OP_PRED, 0, 0);
        send_request(OP_SUCC, 0, 0);
        send_request(OP_RANK, KEY_MAX, 0);
        send_request(OP_DELETE, 5, 0);
        send_request(OP_INSERT, KEY_MIN, 0);
        send_request(OP_INSERT, KEY_MAX, 0);
        send_request(OP_INSERT, 0, 0);
        send_request(OP_INSERT, 0, 0);
        send_request(OP_INSERT, -1, 0);
        send_request(OP_RANK, 0, 0);
        send_request(OP_SELECT, 0, 0);
        send_request(OP_SELECT, 0, 11'd1024);
        send_request(OP_SELECT, -1, 5);
        send_request(OP_PRED, KEY_MIN, 0);
        send_request(OP_SUCC, KEY_MAX, 0);
        send_request(OP_PRED, 0, 0);
        send_request(OP_SUCC, 0, 0);
        send_request(OP_DELETE, 0, 0);
        send_request(OP_RANK, 1, 0);
        send_request(OP_SPARE_LO, -1, 11'd1024);
        send_request(OP_SPARE_HI, KEY_MAX, 3);
        send_request(OP_DELETE, KEY_MIN, 0);
        send_request(OP_DELETE, KEY_MIN, 0);
        send_request(OP_SELECT, 0, 1);

        // mixed traffic, the first stretch with no idling on either side
        for (int i = 0; i < 250; i++)
        begin
            if (i == 80)
                calm <= 1'b0;
            random_request(40, 20);
        end

        // fill to capacity; the long response hold-off lands in here
        guard = 0;
        while (occupancy_now < CAPACITY && guard < 1500)
        begin
            if (guard == 200)
                hold_request <= 1'b1;
            random_request(90, 2);
            guard++;
        end
        for (int i = 0; i < 40; i++)
            random_request(50, 0);
        send_request(OP_RANK, KEY_MAX, 0);
        send_request(OP_SELECT, 0, 11'd1024);
        send_request(OP_INSERT, KEY_MIN, 0);

        // drain
        for (int i = 0; i < 150; i++)
            random_request(15, 55);

        req_valid <= 1'b0;
        while (responses_seen != requests_sent)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d requests through all six operations and both spare codes",
                 requests_sent);
        $display("store peaked at %0d of %0d entries, %0d inserts refused while full",
                 peak_occupancy, CAPACITY, dropped_inserts);
        if (fail_count == 0 && responses_seen == requests_sent)
            $display("tb_ordered_multiset_rank_select_unit OK");
        else
            $display("tb_ordered_multiset_rank_select_unit NOT OK");
        $finish;
    end

endmodule
